// ===== rtl/core/ssr_pkg.sv =====
package ssr_pkg;

  localparam int MUL_W = 16;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W = 32;

  localparam logic [DIV_W-1:0] TIMER_HZ = DIV_W'(2000000);
  localparam logic [DIV_W-1:0] PERIOD_MAX = DIV_W'(65535);
  localparam logic [DIV_W-1:0] US_PER_MS = DIV_W'(1000);

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_MAX_ACCEL = 3'd0,
    REG_MIN_ACCEL = 3'd1,
    REG_LOW_SPEED = 3'd2,
    REG_SPEED_LIM = 3'd3,
    REG_STOP_COEF = 3'd4,
    REG_IDLE_PER  = 3'd5
  } reg_idx_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/core/ssr_mul.sv =====
module ssr_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssr_pkg::MUL_W-1:0]   a,
  input  logic [ssr_pkg::MUL_W-1:0]   b,
  output logic [ssr_pkg::PROD_W-1:0]  prod,
  output ssr_pkg::unit_stat_t         stat
);
  import ssr_pkg::*;

  logic [PROD_W-1:0]        sum_r;
  logic [PROD_W-1:0]        mcand_r;
  logic [MUL_W-1:0]         mplier_r;
  logic [$clog2(MUL_W)-1:0] cnt_r;
  logic                     busy_r;
  logic                     done_r;

  // one multiplier bit per cycle, shift and add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '1);
      if (start) begin
        busy_r   <= 1'b1;
        sum_r    <= '0;
        mcand_r  <= {{(PROD_W-MUL_W){1'b0}}, a};
        mplier_r <= b;
        cnt_r    <= '0;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          sum_r <= sum_r + mcand_r;
        end
        mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[MUL_W-1:1]};
        cnt_r    <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign prod = sum_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/ssr_div.sv =====
module ssr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ssr_pkg::DIV_W-1:0]  dividend,
  input  logic [ssr_pkg::DIV_W-1:0]  divisor,
  output logic [ssr_pkg::DIV_W-1:0]  quotient,
  output ssr_pkg::unit_stat_t        stat
);
  import ssr_pkg::*;

  logic [DIV_W:0]             rem_r;
  logic [DIV_W-1:0]           quo_r;
  logic [DIV_W-1:0]           dsr_r;
  logic [$clog2(DIV_W)-1:0]   cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [DIV_W:0]             shifted;
  logic [DIV_W:0]             trial;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r[DIV_W-1:0], quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '1);
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (!trial[DIV_W]) begin
          rem_r <= trial;
          quo_r <= {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/core/stepper_speed_ramp_unit.sv =====
// channel  | dir | handshake                 | payload
// in_      | in  | in_tvalid / in_tready     | in_tdata: elapsed_us, position,
//          |     |                           |   target_position, cruise_speed
// out_     | out | out_tvalid / out_tready   | out_tdata: speed, direction, step_period
// cfg_     | in  | psel, penable, pwrite     | APB registers at byte address 4*index
//
// one request runs, from acceptance to the output register, up to four 16-bit
// shift-add multiplies and up to four 32-bit restoring divides one after another
// on one shared multiplier and one shared divider, plus an update step and an
// output step
// reset (rst_n low, synchronous) clears the speed to 0 and loads register defaults
// the result sits in an output register; a new request is taken while it waits,
// and the last step of the next request holds until that register is free
module stepper_speed_ramp_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] elapsed_us, [31:16] position, [47:32] target_position,
  // [62:48] cruise_speed, [63] zero
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] speed, [17:16] direction, [33:18] step_period, [39:34] zero
  output logic [39:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ssr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SPAN_MUL,
    S_ACC_DIV,
    S_SQ_MUL,
    S_DEN_MUL,
    S_DIST_DIV,
    S_DT_MUL,
    S_DELTA_DIV,
    S_UPDATE,
    S_PER_DIV,
    S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [14:0] max_accel_r;
  logic [14:0] min_accel_r;
  logic [14:0] low_speed_r;
  logic [14:0] speed_lim_r;
  logic [15:0] stop_coef_r;
  logic [15:0] idle_per_r;

  // per-request working registers
  logic [15:0] spd_r;
  logic [15:0] dt_r;
  logic [15:0] pos_r;
  logic [15:0] goal_r;
  logic [14:0] cruise_r;
  logic [14:0] abs_r;
  logic [14:0] acc_r;
  logic        span_neg_r;
  logic [29:0] sq_r;
  logic [29:0] dist_r;
  logic [20:0] delta_r;
  logic [15:0] period_r;

  logic              out_tvalid_r;
  logic [39:0]       out_tdata_r;

  // shared arithmetic units
  logic              mul_start_r;
  logic              mul_start_nxt;
  logic [MUL_W-1:0]  mul_a_r;
  logic [MUL_W-1:0]  mul_b_r;
  logic [PROD_W-1:0] mul_prod;
  unit_stat_t        mul_stat;
  logic              div_start_r;
  logic              div_start_nxt;
  logic [DIV_W-1:0]  div_n_r;
  logic [DIV_W-1:0]  div_d_r;
  logic [DIV_W-1:0]  div_quo;
  unit_stat_t        div_stat;

  ssr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  ssr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_n_r),
    .divisor  (div_d_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // apb access
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      REG_MAX_ACCEL: cfg_prdata = {17'd0, max_accel_r};
      REG_MIN_ACCEL: cfg_prdata = {17'd0, min_accel_r};
      REG_LOW_SPEED: cfg_prdata = {17'd0, low_speed_r};
      REG_SPEED_LIM: cfg_prdata = {17'd0, speed_lim_r};
      REG_STOP_COEF: cfg_prdata = {16'd0, stop_coef_r};
      REG_IDLE_PER:  cfg_prdata = {16'd0, idle_per_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r <= 15'd10000;
      min_accel_r <= 15'd100;
      low_speed_r <= 15'd2000;
      speed_lim_r <= 15'd32000;
      stop_coef_r <= 16'd2000;
      idle_per_r  <= 16'd65535;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MAX_ACCEL: max_accel_r <= cfg_pwdata[14:0];
        REG_MIN_ACCEL: min_accel_r <= cfg_pwdata[14:0];
        REG_LOW_SPEED: low_speed_r <= cfg_pwdata[14:0];
        REG_SPEED_LIM: speed_lim_r <= cfg_pwdata[14:0];
        REG_STOP_COEF: stop_coef_r <= cfg_pwdata[15:0];
        REG_IDLE_PER:  idle_per_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // speed magnitude and s-curve span at request start
  logic [15:0] neg_spd;
  logic [14:0] abs_spd;
  logic [15:0] span;
  logic [14:0] span_mag;
  assign neg_spd  = 16'd0 - spd_r;
  assign abs_spd  = spd_r[15] ? neg_spd[14:0] : spd_r[14:0];
  assign span     = {1'b0, max_accel_r} - {1'b0, min_accel_r};
  assign span_mag = span[15] ? 15'(16'd0 - span) : span[14:0];

  // quotient of the s-curve is below the span, so the sum stays in range
  logic [14:0] acc_new;
  assign acc_new = span_neg_r ? (min_accel_r - div_quo[14:0])
                              : (min_accel_r + div_quo[14:0]);

  // stop position, target speed and speed step
  logic [31:0] dist_s;
  logic [31:0] stop_pos;
  logic [31:0] pos_x;
  logic [31:0] goal_x;
  logic        fwd;
  logic        stop_hit;
  logic [14:0] cruise_lim;
  logic [17:0] tgt;
  logic [17:0] spd_x;
  logic [17:0] diff;
  logic [17:0] adiff;
  logic [17:0] stepped;
  logic [15:0] spd_new;
  logic [15:0] neg_new;
  logic [14:0] mag_new;

  assign dist_s   = spd_r[15] ? (32'd0 - {2'b00, dist_r}) : {2'b00, dist_r};
  assign pos_x    = {{16{pos_r[15]}}, pos_r};
  assign goal_x   = {{16{goal_r[15]}}, goal_r};
  assign stop_pos = pos_x + dist_s;
  assign fwd      = $signed(goal_r) > $signed(pos_r);
  assign stop_hit = fwd ? ($signed(stop_pos) >= $signed(goal_x))
                        : ($signed(stop_pos) <= $signed(goal_x));
  assign cruise_lim = (cruise_r > speed_lim_r) ? speed_lim_r : cruise_r;
  assign tgt = stop_hit ? 18'd0
             : (fwd ? {3'b000, cruise_lim} : (18'd0 - {3'b000, cruise_lim}));
  assign spd_x   = {{2{spd_r[15]}}, spd_r};
  assign diff    = tgt - spd_x;
  assign adiff   = diff[17] ? (18'd0 - diff) : diff;
  assign stepped = diff[17] ? (spd_x - {2'b00, delta_r[15:0]})
                            : (spd_x + {2'b00, delta_r[15:0]});
  assign spd_new = ({3'b000, adiff} > delta_r) ? stepped[15:0] : tgt[15:0];
  assign neg_new = 16'd0 - spd_new;
  assign mag_new = spd_new[15] ? neg_new[14:0] : spd_new[14:0];

  logic [1:0] dir_code;
  assign dir_code = (spd_r == 16'd0) ? 2'b00 : (spd_r[15] ? 2'b11 : 2'b01);

  // start pulses for the shared units
  always_comb begin
    mul_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    case (state_r)
      S_IDLE:     mul_start_nxt = in_tvalid;
      S_SPAN_MUL: div_start_nxt = mul_stat.done;
      S_ACC_DIV:  mul_start_nxt = div_stat.done;
      S_SQ_MUL:   mul_start_nxt = mul_stat.done;
      S_DEN_MUL: begin
        mul_start_nxt = mul_stat.done && (mul_prod == '0);
        div_start_nxt = mul_stat.done && (mul_prod != '0);
      end
      S_DIST_DIV: mul_start_nxt = div_stat.done;
      S_DT_MUL:   div_start_nxt = mul_stat.done;
      S_UPDATE:   div_start_nxt = (spd_new != 16'd0);
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      spd_r        <= '0;
      out_tvalid_r <= 1'b0;
      mul_start_r  <= 1'b0;
      div_start_r  <= 1'b0;
    end else begin
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            dt_r       <= in_tdata[15:0];
            pos_r      <= in_tdata[31:16];
            goal_r     <= in_tdata[47:32];
            cruise_r   <= in_tdata[62:48];
            abs_r      <= abs_spd;
            span_neg_r <= span[15];
            if (abs_spd < low_speed_r) begin
              mul_a_r <= {1'b0, abs_spd};
              mul_b_r <= {1'b0, span_mag};
              state_r <= S_SPAN_MUL;
            end else begin
              acc_r   <= max_accel_r;
              mul_a_r <= {1'b0, abs_spd};
              mul_b_r <= {1'b0, abs_spd};
              state_r <= S_SQ_MUL;
            end
          end
        end
        S_SPAN_MUL: begin
          if (mul_stat.done) begin
            div_n_r <= mul_prod;
            div_d_r <= {17'd0, low_speed_r};
            state_r <= S_ACC_DIV;
          end
        end
        S_ACC_DIV: begin
          if (div_stat.done) begin
            acc_r   <= acc_new;
            mul_a_r <= {1'b0, abs_r};
            mul_b_r <= {1'b0, abs_r};
            state_r <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: begin
          if (mul_stat.done) begin
            sq_r    <= mul_prod[29:0];
            mul_a_r <= stop_coef_r;
            mul_b_r <= {1'b0, acc_r};
            state_r <= S_DEN_MUL;
          end
        end
        S_DEN_MUL: begin
          if (mul_stat.done) begin
            if (mul_prod == '0) begin
              // zero acceleration or coefficient: no stop distance
              dist_r  <= '0;
              mul_a_r <= {1'b0, acc_r};
              mul_b_r <= dt_r;
              state_r <= S_DT_MUL;
            end else begin
              div_n_r <= {2'b00, sq_r};
              div_d_r <= mul_prod;
              state_r <= S_DIST_DIV;
            end
          end
        end
        S_DIST_DIV: begin
          if (div_stat.done) begin
            dist_r  <= div_quo[29:0];
            mul_a_r <= {1'b0, acc_r};
            mul_b_r <= dt_r;
            state_r <= S_DT_MUL;
          end
        end
        S_DT_MUL: begin
          if (mul_stat.done) begin
            div_n_r <= mul_prod;
            div_d_r <= US_PER_MS;
            state_r <= S_DELTA_DIV;
          end
        end
        S_DELTA_DIV: begin
          if (div_stat.done) begin
            delta_r <= div_quo[20:0];
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          spd_r <= spd_new;
          if (spd_new == 16'd0) begin
            period_r <= idle_per_r;
            state_r  <= S_OUT;
          end else begin
            div_n_r <= TIMER_HZ;
            div_d_r <= {17'd0, mag_new};
            state_r <= S_PER_DIV;
          end
        end
        S_PER_DIV: begin
          if (div_stat.done) begin
            period_r <= (div_quo > PERIOD_MAX) ? idle_per_r : div_quo[15:0];
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'd0, period_r, dir_code, spd_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    spd_r != 16'h8000) else $error("speed left its range");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_stat.busy && div_stat.busy)) else $error("multiplier and divider overlap");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
    else $error("unit busy while idle");

  a_dir_matches_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[17:16] == 2'b00) == (out_tdata[15:0] == 16'd0)))
    else $error("direction disagrees with speed");
`endif

endmodule
